[rtl/core/cslc_pkg.sv]
// Package for the cooler serial link controller.
// Holds request, command and status codes, the control/status structs and the
// ASCII helper functions. No dependencies.
package cslc_pkg;

	localparam int REPLY_LEN = 8;
	localparam int CMD_LEN   = 10;
	localparam int HELD_W    = $clog2(REPLY_LEN + 1);
	localparam int STORE_AW  = $clog2(REPLY_LEN);
	localparam int TX_IDX_W  = $clog2(CMD_LEN);

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_LC_C  = 8'h63;

	typedef enum logic [1:0] {
		REQ_RX   = 2'd0,
		REQ_TICK = 2'd1,
		REQ_SET  = 2'd2,
		REQ_EN   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		CMD_QUERY = 2'd0,
		CMD_SET   = 2'd1,
		CMD_ON    = 2'd2,
		CMD_OFF   = 2'd3
	} cmd_kind_t;

	localparam logic [1:0] RS_VALID    = 2'd0;
	localparam logic [1:0] RS_NO_REPLY = 2'd1;
	localparam logic [1:0] RS_BAD      = 2'd2;

	localparam logic [1:0] CFG_MAX_SET_TEMP    = 2'd0;
	localparam logic [1:0] CFG_NO_REPLY_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_BAD_REPLY_LIMIT = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic                take;  // input word accepted this cycle
		logic [TX_IDX_W-1:0] idx;   // frame byte being shown
	} cslc_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;
	} cslc_sts_t;

	// {ok, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] lower_hex(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
	endfunction

	function automatic logic [7:0] upper_hex(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction

	// Fixed frames: query, on, off
	function automatic logic [7:0] fixed_frame(input cmd_kind_t cmd,
		input logic [TX_IDX_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = CH_STAR;
			4'd1: c = (cmd == CMD_QUERY) ? 8'h30 : 8'h33;
			4'd2: c = (cmd == CMD_QUERY) ? 8'h31 : 8'h30;
			4'd3: c = 8'h30;
			4'd4: c = 8'h30;
			4'd5: c = 8'h30;
			4'd6: c = (cmd == CMD_ON) ? 8'h31 : 8'h30;
			4'd7: c = 8'h32;
			4'd8: begin
				case (cmd)
					CMD_ON:  c = 8'h34;
					CMD_OFF: c = 8'h33;
					default: c = 8'h31;
				endcase
			end
			4'd9: c = CH_CR;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/cslc_if.sv]
// Channel interfaces of the cooler serial link controller: request, reply
// and configuration write. Depends on nothing.
interface cslc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte;
	logic [7:0] set_temp;
	logic       enable_value;

	modport source (output valid, req_type, rx_byte, set_temp, enable_value, input ready);
	modport sink (input valid, req_type, rx_byte, set_temp, enable_value, output ready);
endinterface

interface cslc_rsp_if;
	logic               valid;
	logic               ready;
	logic [7:0]         tx_byte;
	logic               last;
	logic [1:0]         reply_status;
	logic signed [15:0] reading_raw;
	logic               timeout_fault;
	logic               checksum_fault;
	logic [7:0]         computed_sum;
	logic [7:0]         received_sum;

	modport source (output valid, tx_byte, last, reply_status, reading_raw,
		timeout_fault, checksum_fault, computed_sum, received_sum, input ready);
	modport sink (input valid, tx_byte, last, reply_status, reading_raw,
		timeout_fault, checksum_fault, computed_sum, received_sum, output ready);
endinterface

interface cslc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/cslc_ctrl.sv]
// Controller FSM: takes input words and, on a check tick, walks the ten command frame bytes.
// Depends on cslc_pkg.
module cslc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	input  cslc_pkg::cslc_sts_t    sts,
	output cslc_pkg::cslc_ctl_t    ctl
);

	typedef enum logic {
		S_IDLE,
		S_SEND
	} state_t;

	localparam logic [cslc_pkg::TX_IDX_W-1:0] LAST_IDX =
		cslc_pkg::TX_IDX_W'(cslc_pkg::CMD_LEN - 1);

	state_t                        state_q;
	logic                          req_ready_q;
	logic                          rsp_valid_q;
	logic [cslc_pkg::TX_IDX_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_ready_q <= 1'b1;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && sts.is_tick) begin
						state_q     <= S_SEND;
						req_ready_q <= 1'b0;
						rsp_valid_q <= 1'b1;
						idx_q       <= '0;
					end
				end
				S_SEND: begin
					if (rsp_ready) begin
						if (idx_q == LAST_IDX) begin
							state_q     <= S_IDLE;
							req_ready_q <= 1'b1;
							rsp_valid_q <= 1'b0;
							idx_q       <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q     <= S_IDLE;
					req_ready_q <= 1'b1;
					rsp_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign req_ready = req_ready_q;
	assign rsp_valid = rsp_valid_q;
	assign ctl.take  = req_valid && req_ready_q;
	assign ctl.idx   = idx_q;

endmodule

[rtl/core/cslc_datapath.sv]
// Datapath: config registers, reply frame store, pending command, reply
// judgement and frame byte generation. Depends on cslc_pkg.
module cslc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cslc_pkg::cslc_ctl_t ctl,
	output cslc_pkg::cslc_sts_t sts,
	input  logic [1:0]          req_type,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          set_temp,
	input  logic                enable_value,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output logic [7:0]          tx_byte,
	output logic                last,
	output logic [1:0]          reply_status,
	output logic signed [15:0]  reading_raw,
	output logic                timeout_fault,
	output logic                checksum_fault,
	output logic [7:0]          computed_sum,
	output logic [7:0]          received_sum
);

	localparam logic [cslc_pkg::HELD_W-1:0] FULL =
		cslc_pkg::HELD_W'(cslc_pkg::REPLY_LEN);
	localparam logic [cslc_pkg::TX_IDX_W-1:0] LAST_IDX =
		cslc_pkg::TX_IDX_W'(cslc_pkg::CMD_LEN - 1);

	logic [7:0] max_set_temp_q, no_reply_limit_q, bad_reply_limit_q;
	logic [7:0] store_q [cslc_pkg::REPLY_LEN];
	logic [cslc_pkg::HELD_W-1:0] held_q;
	cslc_pkg::cmd_kind_t pend_q;
	logic [7:0] target_q;
	logic [7:0] miss_cnt_q, bad_cnt_q;

	// latched at the tick for the frame being sent
	cslc_pkg::cmd_kind_t cmd_q;
	logic [11:0]         temp10_q;
	logic [1:0]          status_q;
	logic [15:0]         raw_q;
	logic                tfault_q, cfault_q;
	logic [7:0]          csum_q, rsum_q;

	cslc_pkg::req_kind_t kind;
	logic                tick;
	logic [4:0]          h [1:6];
	logic [7:0]          csum, rsum;
	logic                ok, full;
	logic [7:0]          miss_inc, bad_inc;
	logic [11:0]         temp10;

	assign kind        = cslc_pkg::req_kind_t'(req_type);
	assign sts.is_tick = (kind == cslc_pkg::REQ_TICK);
	assign tick        = ctl.take && sts.is_tick;

	always_comb begin
		for (int k = 1; k <= 6; k++)
			h[k] = cslc_pkg::hex_val(store_q[k]);
		csum = store_q[1] + store_q[2] + store_q[3] + store_q[4];
		// checksum digits taken from the left up to the first non-hex char
		if (h[5][4])
			rsum = h[6][4] ? {h[5][3:0], h[6][3:0]} : {4'd0, h[5][3:0]};
		else
			rsum = 8'd0;
		ok = (store_q[0] == cslc_pkg::CH_STAR) && h[1][4] && h[2][4] && h[3][4] &&
			h[4][4] && h[5][4] && h[6][4] && (store_q[7] == cslc_pkg::CH_CARET) &&
			(csum == rsum);
		full     = (held_q >= FULL);
		miss_inc = miss_cnt_q + 8'd1;
		bad_inc  = bad_cnt_q + 8'd1;
		temp10   = {1'b0, target_q, 3'd0} + {3'd0, target_q, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_set_temp_q    <= 8'd40;
			no_reply_limit_q  <= 8'd3;
			bad_reply_limit_q <= 8'd3;
			held_q            <= '0;
			pend_q            <= cslc_pkg::CMD_QUERY;
			target_q          <= 8'd0;
			miss_cnt_q        <= 8'd0;
			bad_cnt_q         <= 8'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cslc_pkg::CFG_MAX_SET_TEMP:    max_set_temp_q    <= cfg_data;
					cslc_pkg::CFG_NO_REPLY_LIMIT:  no_reply_limit_q  <= cfg_data;
					cslc_pkg::CFG_BAD_REPLY_LIMIT: bad_reply_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.take) begin
				case (kind)
					cslc_pkg::REQ_RX: begin
						if (!full)
							held_q <= held_q + 1'b1;
					end
					cslc_pkg::REQ_SET: begin
						if (set_temp <= max_set_temp_q) begin
							target_q <= set_temp;
							pend_q   <= cslc_pkg::CMD_SET;
						end
					end
					cslc_pkg::REQ_EN: begin
						pend_q <= enable_value ? cslc_pkg::CMD_ON : cslc_pkg::CMD_OFF;
					end
					cslc_pkg::REQ_TICK: begin
						pend_q <= cslc_pkg::CMD_QUERY;
						held_q <= '0;
						if (!full) begin
							miss_cnt_q <= (miss_inc >= no_reply_limit_q) ? 8'd0 : miss_inc;
						end else begin
							miss_cnt_q <= 8'd0;
							if (!ok)
								bad_cnt_q <= (bad_inc >= bad_reply_limit_q) ? 8'd0 : bad_inc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take && kind == cslc_pkg::REQ_RX && !full)
			store_q[held_q[cslc_pkg::STORE_AW-1:0]] <= rx_byte;
		if (tick) begin
			cmd_q    <= pend_q;
			temp10_q <= temp10;
			if (!full) begin
				status_q <= cslc_pkg::RS_NO_REPLY;
				raw_q    <= 16'd0;
				tfault_q <= (miss_inc >= no_reply_limit_q);
				cfault_q <= 1'b0;
				csum_q   <= 8'd0;
				rsum_q   <= 8'd0;
			end else begin
				status_q <= ok ? cslc_pkg::RS_VALID : cslc_pkg::RS_BAD;
				raw_q    <= ok ? {h[1][3:0], h[2][3:0], h[3][3:0], h[4][3:0]} : 16'd0;
				tfault_q <= 1'b0;
				cfault_q <= !ok && (bad_inc >= bad_reply_limit_q);
				csum_q   <= csum;
				rsum_q   <= rsum;
			end
		end
	end

	// frame byte for the current index
	logic [7:0] set_c [3:6];
	logic [7:0] set_sum;
	logic       fin;

	always_comb begin
		set_c[3] = cslc_pkg::lower_hex(4'd0);
		set_c[4] = cslc_pkg::lower_hex(temp10_q[11:8]);
		set_c[5] = cslc_pkg::lower_hex(temp10_q[7:4]);
		set_c[6] = cslc_pkg::lower_hex(temp10_q[3:0]);
		set_sum  = cslc_pkg::CH_ONE + cslc_pkg::CH_LC_C + set_c[3] + set_c[4] +
			set_c[5] + set_c[6];
		if (cmd_q == cslc_pkg::CMD_SET) begin
			case (ctl.idx)
				4'd0:    tx_byte = cslc_pkg::CH_STAR;
				4'd1:    tx_byte = cslc_pkg::CH_ONE;
				4'd2:    tx_byte = cslc_pkg::CH_LC_C;
				4'd3:    tx_byte = set_c[3];
				4'd4:    tx_byte = set_c[4];
				4'd5:    tx_byte = set_c[5];
				4'd6:    tx_byte = set_c[6];
				4'd7:    tx_byte = cslc_pkg::upper_hex(set_sum[7:4]);
				4'd8:    tx_byte = cslc_pkg::upper_hex(set_sum[3:0]);
				default: tx_byte = cslc_pkg::CH_CR;
			endcase
		end else begin
			tx_byte = cslc_pkg::fixed_frame(cmd_q, ctl.idx);
		end
		fin = (ctl.idx == LAST_IDX);
	end

	assign last           = fin;
	assign reply_status   = fin ? status_q : 2'd0;
	assign reading_raw    = fin ? $signed(raw_q) : 16'sd0;
	assign timeout_fault  = fin && tfault_q;
	assign checksum_fault = fin && cfault_q;
	assign computed_sum   = fin ? csum_q : 8'd0;
	assign received_sum   = fin ? rsum_q : 8'd0;

endmodule

[rtl/core/cooler_serial_link_controller_top.sv]
// Top level of the cooler serial link controller.
// Depends on cslc_pkg, cslc_if, cslc_ctrl and cslc_datapath.
//
//  channel | interface    | word
//  --------+--------------+------------------------------------------------
//  req     | cslc_req_if  | req_type, rx_byte, set_temp, enable_value
//  rsp     | cslc_rsp_if  | tx_byte, last, status, reading, faults, sums
//  cfg     | cslc_cfg_if  | index (0..2), data (8 bit); always ready
//
// Received byte, set and enable words are each accepted while req.ready is high.
// A check tick is accepted, then sends ten frame bytes, one a cycle while
// rsp.ready is high; the controller's byte counter sets this. No new req word
// is taken until the tenth byte is gone. A stall on rsp holds the byte shown.
// Reset clears control state and loads register defaults; no clearing pass.
module cooler_serial_link_controller_top (
	input logic         clk,
	input logic         arst_n,
	cslc_req_if.sink    req,
	cslc_rsp_if.source  rsp,
	cslc_cfg_if.sink    cfg
);

	cslc_pkg::cslc_ctl_t ctl;
	cslc_pkg::cslc_sts_t sts;

	assign cfg.ready = 1'b1;

	cslc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	cslc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.req_type       (req.req_type),
		.rx_byte        (req.rx_byte),
		.set_temp       (req.set_temp),
		.enable_value   (req.enable_value),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.tx_byte        (rsp.tx_byte),
		.last           (rsp.last),
		.reply_status   (rsp.reply_status),
		.reading_raw    (rsp.reading_raw),
		.timeout_fault  (rsp.timeout_fault),
		.checksum_fault (rsp.checksum_fault),
		.computed_sum   (rsp.computed_sum),
		.received_sum   (rsp.received_sum)
	);

endmodule

[rtl/core/cslc_checker.sv]
// Port-level checker for the cooler serial link controller, bound to the top.
// Depends on cslc_pkg.
module cslc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_last,
	input logic [1:0]        reply_status,
	input logic signed [15:0] reading_raw,
	input logic              timeout_fault,
	input logic              checksum_fault,
	input logic [7:0]        computed_sum,
	input logic [7:0]        received_sum
);

	// side fields only carry data on the tenth byte
	a_quiet_body: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> reply_status == cslc_pkg::RS_VALID &&
		reading_raw == 16'sd0 && !timeout_fault && !checksum_fault &&
		computed_sum == 8'd0 && received_sum == 8'd0)
		else $error("status fields set before last byte");

	// no new request word while a frame is going out
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken during frame send");

	a_no_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_last && reply_status == cslc_pkg::RS_NO_REPLY |->
		reading_raw == 16'sd0 && computed_sum == 8'd0 && received_sum == 8'd0 &&
		!checksum_fault)
		else $error("no-reply status with reply data");

	a_valid_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_last && reply_status == cslc_pkg::RS_VALID |->
		computed_sum == received_sum && !timeout_fault && !checksum_fault)
		else $error("valid reading with checksum mismatch or fault");

endmodule

bind cooler_serial_link_controller_top cslc_checker u_cslc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_last       (rsp.last),
	.reply_status   (rsp.reply_status),
	.reading_raw    (rsp.reading_raw),
	.timeout_fault  (rsp.timeout_fault),
	.checksum_fault (rsp.checksum_fault),
	.computed_sum   (rsp.computed_sum),
	.received_sum   (rsp.received_sum)
);
